// File: hdl/bclb_pkg.sv
package bclb_pkg;

    typedef logic [2:0] t_req;
    typedef logic [7:0] t_byte;
    typedef logic [23:0] t_name;

    localparam t_req REQ_MINSEC    = 3'd0;
    localparam t_req REQ_HOURS     = 3'd1;
    localparam t_req REQ_DAY_NAME  = 3'd2;
    localparam t_req REQ_DATE      = 3'd3;
    localparam t_req REQ_MON_DIGIT = 3'd4;
    localparam t_req REQ_MON_NAME  = 3'd5;
    localparam t_req REQ_YEAR2     = 3'd6;
    localparam t_req REQ_YEAR4     = 3'd7;

    localparam t_byte LCD_SET_ADDR  = 8'h80;
    localparam t_byte ASCII_ZERO    = 8'h30;
    localparam t_byte CENTURY_SPLIT = 8'd20;

    localparam logic [2:0] LEN_DIGITS = 3'd3;
    localparam logic [2:0] LEN_NAME   = 3'd4;
    localparam logic [2:0] LEN_YEAR4  = 3'd5;

    function automatic t_name day_name(input logic [2:0] sel);
        t_name name;
        case (sel)
            3'd1: name = "Mon";
            3'd2: name = "Tue";
            3'd3: name = "Wed";
            3'd4: name = "Thu";
            3'd5: name = "Fri";
            3'd6: name = "Sat";
            3'd7: name = "Sun";
            default: name = "Unk";
        endcase
        return name;
    endfunction

    function automatic t_name month_name(input logic [3:0] sel);
        t_name name;
        case (sel)
            4'd1:  name = "Jan";
            4'd2:  name = "Feb";
            4'd3:  name = "Mar";
            4'd4:  name = "Apr";
            4'd5:  name = "May";
            4'd6:  name = "Jun";
            4'd7:  name = "Jul";
            4'd8:  name = "Aug";
            4'd9:  name = "Sep";
            4'd10: name = "Oct";
            4'd11: name = "Nov";
            4'd12: name = "Dec";
            default: name = "Unk";
        endcase
        return name;
    endfunction

    function automatic t_byte digit_char(input logic [3:0] d);
        return ASCII_ZERO + {4'b0, d};
    endfunction

endpackage

// File: hdl/bcd_clock_field_to_lcd_bytes_unit.sv
// A taken item is first registered, and its bytes are then registered into o_lcd_byte.
// Run length: 3 bytes for digit fields and two-digit year, 4 for names, 5 for four-digit year.
// A new item can be taken only while the final byte of the current one is being registered.
// One byte per cycle from a byte counter over the registered item; the receiver cannot stall.
// Synchronous active-low reset clears the run state and the strobe.
module bcd_clock_field_to_lcd_bytes_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bclb_pkg::t_req   i_req_type,
    input  logic [7:0]       i_bcd_value,
    input  logic [5:0]       i_column,
    input  logic             i_row,
    output logic             o_strobe,
    output bclb_pkg::t_byte  o_lcd_byte,
    output logic             o_is_char,
    output logic             o_last
);
    import bclb_pkg::*;

    logic        r_active;
    logic [2:0]  r_idx;
    t_req        r_type;
    logic [7:0]  r_bcd;
    logic [5:0]  r_col;
    logic        r_row;

    logic        accept;
    logic        fin;
    logic [2:0]  n_len;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [3:0]  tens;
    logic [6:0]  addr;
    logic [7:0]  year_val;
    logic        year_old;
    logic [4:0]  mon_idx;
    logic [2:0]  day_sel;
    logic [3:0]  mon_sel;
    t_name       name;
    t_byte       n_byte;

    assign hi = r_bcd[7:4];
    assign lo = r_bcd[3:0];

    always_comb begin
        case (r_type)
            REQ_DAY_NAME, REQ_MON_NAME: n_len = LEN_NAME;
            REQ_YEAR4:                  n_len = LEN_YEAR4;
            default:                    n_len = LEN_DIGITS;
        endcase
    end

    assign fin    = r_idx == (n_len - 3'd1);
    assign busy   = r_active && !fin;
    assign accept = start && !busy;

    always_comb begin
        case (r_type)
            REQ_MINSEC:    tens = {1'b0, hi[2:0]};
            REQ_HOURS:     tens = {2'b0, hi[1:0]};
            REQ_DATE:      tens = {2'b0, hi[1:0]};
            REQ_MON_DIGIT: tens = {3'b0, hi[0]};
            default:       tens = hi;
        endcase
    end

    assign addr     = {1'b0, r_col} + (r_row ? 7'h40 : 7'h00);
    assign year_val = {1'b0, hi, 3'b0} + {3'b0, hi, 1'b0} + {4'b0, lo};
    assign year_old = year_val > CENTURY_SPLIT;
    assign mon_idx  = (r_bcd[4] ? 5'd10 : 5'd0) + {1'b0, lo};
    assign day_sel  = (r_bcd >= 8'd1 && r_bcd <= 8'd7) ? r_bcd[2:0] : 3'd0;
    assign mon_sel  = (mon_idx >= 5'd1 && mon_idx <= 5'd12) ? mon_idx[3:0] : 4'd0;
    assign name     = (r_type == REQ_DAY_NAME) ? day_name(day_sel) : month_name(mon_sel);

    always_comb begin
        n_byte = LCD_SET_ADDR | {1'b0, addr};
        if (r_idx != 3'd0) begin
            case (r_type)
                REQ_DAY_NAME, REQ_MON_NAME: begin
                    case (r_idx)
                        3'd1:    n_byte = name[23:16];
                        3'd2:    n_byte = name[15:8];
                        default: n_byte = name[7:0];
                    endcase
                end
                REQ_YEAR4: begin
                    case (r_idx)
                        3'd1:    n_byte = digit_char(year_old ? 4'd1 : 4'd2);
                        3'd2:    n_byte = digit_char(year_old ? 4'd9 : 4'd0);
                        3'd3:    n_byte = digit_char(hi);
                        default: n_byte = digit_char(lo);
                    endcase
                end
                default: begin
                    n_byte = (r_idx == 3'd1) ? digit_char(tens) : digit_char(lo);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= 3'd0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_active;
            if (accept) begin
                r_active <= 1'b1;
                r_idx    <= 3'd0;
            end else if (r_active) begin
                r_idx <= r_idx + 3'd1;
                if (fin) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_req_type;
            r_bcd  <= i_bcd_value;
            r_col  <= i_column;
            r_row  <= i_row;
        end
        if (r_active) begin
            o_lcd_byte <= n_byte;
            o_is_char  <= r_idx != 3'd0;
            o_last     <= fin;
        end
    end

`ifndef SYNTHESIS
    a_first_is_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 (o_strobe && !o_is_char && !o_last))
        else $error("first byte of a run is not a position command");

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |=> o_strobe)
        else $error("active run produced no byte");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |=> !o_strobe)
        else $error("byte strobed with no run active");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx < n_len))
        else $error("byte counter beyond run length");

    a_busy_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_active)
        else $error("busy without an active run");
`endif

endmodule
